// ===== rtl/cfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the compact field encoder.
// No dependencies.
package cfe_pkg;

   // Field kinds carried on the request channel
   typedef enum logic [1:0] {
      MODE_COUNT    = 2'd0,
      MODE_UNSIGNED = 2'd1,
      MODE_SIGNED   = 2'd2,
      MODE_TEXT     = 2'd3
   } mode_type;

   localparam int MODE_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int BYTE_W   = 8;
   // Text header carries the length in six bits
   localparam int LEN_W    = 6;
   localparam int SIZE_W   = 3;

   localparam int MAX_TEXT_BYTES_DEF = 63;

   localparam logic [BYTE_W-1:0] HDR_LAST   = 8'h80;
   localparam logic [BYTE_W-1:0] HDR_TEXT   = 8'h40;
   localparam logic [BYTE_W-1:0] HDR_SIGNED = 8'h20;
   localparam logic [BYTE_W-1:0] COUNT_MAX  = 8'hFF;

endpackage

// ===== rtl/cfe_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cfe_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/compact_field_encoder_core.sv =====
`timescale 1ns / 1ps
// Top level of the compact field encoder: sequencer, output register, text buffer.
// Depends on cfe_pkg and cfe_ram.

// One request transaction is taken at a time and its bytes leave through a single output
// register, one byte per cycle while rsp_ready is high. A count field emits one byte, an
// integer field its header and n = 1..4 value bytes. A string byte without field_end emits
// nothing; the closing byte emits the header, then after the first text buffer read in
// ST_STR_PRIME the L kept bytes follow (only the header when L is zero). The buffer RAM's
// single read port and registered read set the drain rate. Strings keep at most
// MAX_TEXT_BYTES bytes and stop at the first NUL.
module compact_field_encoder_core #(
   parameter int MAX_TEXT_BYTES = cfe_pkg::MAX_TEXT_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cfe_pkg::MODE_W-1:0]   req_mode,
   input  logic [cfe_pkg::VALUE_W-1:0]  req_value,
   input  logic                         req_field_end,
   input  logic                         req_last_field,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cfe_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_run_last
);
   import cfe_pkg::*;

   localparam int ADDR_W = (MAX_TEXT_BYTES > 1) ? $clog2(MAX_TEXT_BYTES) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INT,
      ST_STR_PRIME,
      ST_STR
   } state_type;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [SIZE_W-1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]    text_length_ff, text_length_in;
   logic                nul_seen_ff, nul_seen_in;
   logic [LEN_W-1:0]    str_len_ff, str_len_in;
   logic [LEN_W-1:0]    idx_ff, idx_in;

   logic                out_free;
   logic                accept;
   logic [BYTE_W-1:0]   text_byte;
   logic                keep;
   logic [LEN_W-1:0]    new_len;
   logic [SIZE_W-1:0]   usize;
   logic [SIZE_W-1:0]   ssize;
   logic                wr_en;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [BYTE_W-1:0]   rd_data;
   logic [LEN_W-1:0]    idx_next;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign text_byte = req_value[BYTE_W-1:0];
   assign keep      = !nul_seen_ff && (text_byte != '0)
                      && (text_length_ff < LEN_W'(MAX_TEXT_BYTES));
   assign new_len   = text_length_ff + LEN_W'(keep);
   assign wr_en     = accept && (mode_type'(req_mode) == MODE_TEXT) && keep;
   assign idx_next  = idx_ff + LEN_W'(1);

   // Minimal byte counts for the integer forms
   always_comb begin
      if (req_value[31:24] != '0)      usize = SIZE_W'(4);
      else if (req_value[23:16] != '0) usize = SIZE_W'(3);
      else if (req_value[15:8] != '0)  usize = SIZE_W'(2);
      else                             usize = SIZE_W'(1);

      // two's complement fits when all bits above the kept sign bit match it
      if ((req_value[31:7] == '0) || (req_value[31:7] == '1))        ssize = SIZE_W'(1);
      else if ((req_value[31:15] == '0) || (req_value[31:15] == '1)) ssize = SIZE_W'(2);
      else if ((req_value[31:23] == '0) || (req_value[31:23] == '1)) ssize = SIZE_W'(3);
      else                                                           ssize = SIZE_W'(4);
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      value_in       = value_ff;
      rem_in         = rem_ff;
      text_length_in = text_length_ff;
      nul_seen_in    = nul_seen_ff;
      str_len_in     = str_len_ff;
      idx_in         = idx_ff;
      rd_en          = 1'b0;
      rd_addr        = idx_next[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode_type'(req_mode))
                  MODE_COUNT: begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = (req_value[31:8] != '0) ? COUNT_MAX : text_byte;
                     rsp_last_in  = 1'b1;
                  end
                  MODE_UNSIGNED: begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = (req_last_field ? HDR_LAST : '0) | BYTE_W'(usize);
                     rsp_last_in  = 1'b0;
                     value_in     = req_value;
                     rem_in       = usize;
                     state_in     = ST_INT;
                  end
                  MODE_SIGNED: begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = (req_last_field ? HDR_LAST : '0) | HDR_SIGNED
                                    | BYTE_W'(ssize);
                     rsp_last_in  = 1'b0;
                     value_in     = req_value;
                     rem_in       = ssize;
                     state_in     = ST_INT;
                  end
                  MODE_TEXT: begin
                     if (text_byte == '0) begin
                        nul_seen_in = 1'b1;
                     end
                     text_length_in = new_len;
                     if (req_field_end) begin
                        rsp_valid_in   = 1'b1;
                        rsp_byte_in    = (req_last_field ? HDR_LAST : '0) | HDR_TEXT
                                         | BYTE_W'(new_len);
                        rsp_last_in    = (new_len == '0);
                        str_len_in     = new_len;
                        text_length_in = '0;
                        nul_seen_in    = 1'b0;
                        state_in       = (new_len == '0) ? ST_IDLE : ST_STR_PRIME;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               case (rem_ff)
                  SIZE_W'(4): rsp_byte_in = value_ff[31:24];
                  SIZE_W'(3): rsp_byte_in = value_ff[23:16];
                  SIZE_W'(2): rsp_byte_in = value_ff[15:8];
                  default:    rsp_byte_in = value_ff[7:0];
               endcase
               rsp_last_in = (rem_ff == SIZE_W'(1));
               rem_in      = rem_ff - SIZE_W'(1);
               if (rem_ff == SIZE_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STR_PRIME: begin
            // first read issued in the cycle after the closing write lands
            rd_en    = 1'b1;
            rd_addr  = '0;
            idx_in   = '0;
            state_in = ST_STR;
         end
         ST_STR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data;
               rsp_last_in  = (idx_next == str_len_ff);
               if (idx_next == str_len_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en  = 1'b1;
                  idx_in = idx_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         text_length_ff <= '0;
         nul_seen_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         text_length_ff <= text_length_in;
         nul_seen_ff    <= nul_seen_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      value_ff    <= value_in;
      rem_ff      <= rem_in;
      str_len_ff  <= str_len_in;
      idx_ff      <= idx_in;
   end

   cfe_ram #(
      .WIDTH  (BYTE_W),
      .DEPTH  (MAX_TEXT_BYTES),
      .ADDR_W (ADDR_W)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (text_length_ff[ADDR_W-1:0]),
      .wr_data (text_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      text_length_ff <= LEN_W'(MAX_TEXT_BYTES))
      else $error("text length beyond buffer depth");

   a_int_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INT |-> rem_ff != '0)
      else $error("integer burst with no bytes left");

   a_str_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STR |-> idx_ff < str_len_ff)
      else $error("text read past kept length");

   a_nul_no_write: assert property (@(posedge clock) disable iff (reset)
      nul_seen_ff |-> !wr_en)
      else $error("text byte stored after NUL");

   a_count_one: assert property (@(posedge clock) disable iff (reset)
      accept && (mode_type'(req_mode) == MODE_COUNT) |=> rsp_valid_ff && rsp_last_ff)
      else $error("count transaction did not give a single final byte");
`endif

endmodule
